FILE: rtl/mpg_pkg.sv
// Shared types, codes and helpers of the motion presence guard.
package mpg_pkg;

	// Guard states, one-hot
	typedef enum logic [6:0] {
		ST_DISABLED       = 7'b0000001,
		ST_IDLE           = 7'b0000010,
		ST_CAND_PENDING   = 7'b0000100,
		ST_CANDIDATE      = 7'b0001000,
		ST_ABSENT_PENDING = 7'b0010000,
		ST_ABSENT         = 7'b0100000,
		ST_FAULT          = 7'b1000000
	} state_t;

	// Item modes
	typedef enum logic [1:0] {
		MODE_SAMPLE = 2'd0,
		MODE_START  = 2'd1,
		MODE_STOP   = 2'd2,
		MODE_FAULT  = 2'd3
	} mode_t;

	// Fault codes
	localparam logic [1:0] FAULT_NONE    = 2'd0;
	localparam logic [1:0] FAULT_CAMERA  = 2'd1;
	localparam logic [1:0] FAULT_CAPTURE = 2'd2;

	// Register indexes
	localparam logic [2:0] REG_SAMPLE_PERIOD = 3'd0;
	localparam logic [2:0] REG_ON_LEVEL      = 3'd1;
	localparam logic [2:0] REG_OFF_LEVEL     = 3'd2;
	localparam logic [2:0] REG_DEBOUNCE      = 3'd3;
	localparam logic [2:0] REG_ABSENCE       = 3'd4;
	localparam logic [2:0] REG_FAIL_LIMIT    = 3'd5;

	localparam logic [31:0] MIN_PERIOD = 32'd200;
	localparam logic [7:0]  RUN_MAX    = 8'hFF;

	// Encoded state numbers on the result port
	localparam logic [2:0] CODE_DISABLED       = 3'd0;
	localparam logic [2:0] CODE_IDLE           = 3'd1;
	localparam logic [2:0] CODE_CAND_PENDING   = 3'd2;
	localparam logic [2:0] CODE_CANDIDATE      = 3'd3;
	localparam logic [2:0] CODE_ABSENT_PENDING = 3'd4;
	localparam logic [2:0] CODE_ABSENT         = 3'd5;
	localparam logic [2:0] CODE_FAULT          = 3'd6;

	typedef struct packed {
		mode_t       mode;
		logic [31:0] now_time;
		logic [31:0] score;
		logic        frame_good;
		logic        score_good;
		logic [1:0]  fault_in;
	} item_t;

	typedef struct packed {
		logic [31:0] sample_period;
		logic [31:0] on_level;
		logic [31:0] off_level;
		logic [31:0] debounce_time;
		logic [31:0] absence_time;
		logic [7:0]  failure_limit;
	} cfg_t;

	typedef struct packed {
		state_t      state;
		logic [1:0]  fault;
		logic [31:0] epoch;
		logic [31:0] sequence_cnt;
		logic [7:0]  bad_run;
		logic [31:0] pending_start;
		logic [31:0] last_motion;
	} ctx_t;

	function automatic logic [2:0] state_code(state_t st);
		logic [2:0] code;
		unique case (st)
			ST_DISABLED:       code = CODE_DISABLED;
			ST_IDLE:           code = CODE_IDLE;
			ST_CAND_PENDING:   code = CODE_CAND_PENDING;
			ST_CANDIDATE:      code = CODE_CANDIDATE;
			ST_ABSENT_PENDING: code = CODE_ABSENT_PENDING;
			ST_ABSENT:         code = CODE_ABSENT;
			ST_FAULT:          code = CODE_FAULT;
			default:           code = CODE_DISABLED;
		endcase
		return code;
	endfunction

endpackage

FILE: rtl/mpg_step.sv
// Next-context logic of the presence guard for one item.
module mpg_step import mpg_pkg::*; (
	input  ctx_t        cur,
	input  item_t       item,
	input  cfg_t        cfg,
	output ctx_t        nxt,
	output logic [31:0] score_echo
);

	logic [31:0] period_eff;
	logic [31:0] off_eff;
	logic [31:0] deb_eff;
	logic [32:0] abs_eff;
	logic [7:0]  lim_eff;
	logic [7:0]  run_inc;
	logic [31:0] seq_inc;
	logic [31:0] since_pending;
	logic [31:0] since_motion;
	logic [1:0]  fcode;
	logic        motion;
	logic        cleared;
	logic        bad;

	// Apply register clamps
	always_comb begin
		period_eff = (cfg.sample_period < MIN_PERIOD) ? MIN_PERIOD : cfg.sample_period;
		off_eff    = (cfg.off_level > cfg.on_level) ? cfg.on_level : cfg.off_level;
		deb_eff    = (cfg.debounce_time < period_eff) ? period_eff : cfg.debounce_time;
		abs_eff    = ({1'b0, cfg.absence_time} < {period_eff, 1'b0}) ?
		             {period_eff, 1'b0} : {1'b0, cfg.absence_time};
		lim_eff    = (cfg.failure_limit == 8'd0) ? 8'd1 : cfg.failure_limit;
	end

	assign run_inc       = (cur.bad_run == RUN_MAX) ? RUN_MAX : cur.bad_run + 8'd1;
	assign seq_inc       = cur.sequence_cnt + 32'd1;
	assign since_pending = item.now_time - cur.pending_start;
	assign since_motion  = item.now_time - cur.last_motion;
	assign fcode         = (item.fault_in > FAULT_CAPTURE) ? FAULT_CAPTURE : item.fault_in;
	assign motion        = item.score >= cfg.on_level;
	assign cleared       = item.score <= off_eff;
	assign bad           = !item.frame_good || !item.score_good;

	always_comb begin
		nxt        = cur;
		score_echo = '0;
		unique case (item.mode)
			MODE_SAMPLE: begin
				score_echo = item.score;
				if (cur.state != ST_DISABLED && cur.state != ST_FAULT) begin
					if (bad) begin
						nxt.bad_run = run_inc;
						if (run_inc >= lim_eff) begin
							nxt.state        = ST_FAULT;
							nxt.fault        = FAULT_CAPTURE;
							nxt.sequence_cnt = seq_inc;
						end
					end else begin
						nxt.bad_run = '0;
						unique case (cur.state)
							ST_IDLE, ST_ABSENT: begin
								if (motion) begin
									nxt.epoch         = cur.epoch + 32'd1;
									nxt.pending_start = item.now_time;
									nxt.last_motion   = item.now_time;
									nxt.state         = ST_CAND_PENDING;
									nxt.fault         = FAULT_NONE;
									nxt.sequence_cnt  = seq_inc;
								end
							end
							ST_CAND_PENDING: begin
								if (cleared) begin
									nxt.pending_start = '0;
									nxt.last_motion   = '0;
									nxt.state         = ST_IDLE;
									nxt.fault         = FAULT_NONE;
									nxt.sequence_cnt  = seq_inc;
								end else begin
									if (motion) begin
										nxt.last_motion = item.now_time;
									end
									if (since_pending >= deb_eff) begin
										nxt.state        = ST_CANDIDATE;
										nxt.fault        = FAULT_NONE;
										nxt.sequence_cnt = seq_inc;
									end
								end
							end
							ST_CANDIDATE: begin
								if (motion) begin
									nxt.last_motion = item.now_time;
								end else if (cleared) begin
									nxt.state        = ST_ABSENT_PENDING;
									nxt.fault        = FAULT_NONE;
									nxt.sequence_cnt = seq_inc;
								end
							end
							ST_ABSENT_PENDING: begin
								if (motion) begin
									nxt.last_motion  = item.now_time;
									nxt.state        = ST_CANDIDATE;
									nxt.fault        = FAULT_NONE;
									nxt.sequence_cnt = seq_inc;
								end else if (cur.last_motion != 32'd0 &&
								             {1'b0, since_motion} >= abs_eff) begin
									nxt.state        = ST_ABSENT;
									nxt.fault        = FAULT_NONE;
									nxt.sequence_cnt = seq_inc;
								end
							end
							default: begin
							end
						endcase
					end
				end
			end
			MODE_START: begin
				nxt.epoch         = cur.epoch + 32'd1;
				nxt.bad_run       = '0;
				nxt.pending_start = '0;
				nxt.last_motion   = '0;
				nxt.state         = ST_IDLE;
				nxt.fault         = FAULT_NONE;
				nxt.sequence_cnt  = seq_inc;
			end
			MODE_STOP: begin
				nxt.bad_run       = '0;
				nxt.pending_start = '0;
				nxt.last_motion   = '0;
				nxt.state         = ST_DISABLED;
				nxt.fault         = FAULT_NONE;
				nxt.sequence_cnt  = seq_inc;
			end
			MODE_FAULT: begin
				nxt.state        = ST_FAULT;
				nxt.fault        = fcode;
				nxt.sequence_cnt = seq_inc;
			end
		endcase
	end

endmodule

FILE: rtl/motion_presence_guard_fsm.sv
// Top level of the motion presence guard: channels, registers and context.
//
// Usage:
//   Input beats (mode, now_time, score_in, frame_good, score_good, fault_in)
//   enter on in_valid/in_ready. Each beat yields exactly one result beat on
//   out_valid/out_ready carrying epoch, sequence, state, fault code, echoed
//   score and time, and the time motion was last seen.
//   Configuration beats on cfg_valid/cfg_ready write register cfg_index
//   (0 sample period .. 5 failure limit) with cfg_data; indexes above five
//   are dropped. cfg_ready is always high; write only while the guard idles.
//   Path: an input beat lands in the input register; the new context is
//   then computed and loaded with the result into the result register,
//   from which the result leaves on out_valid/out_ready.
//   Throughput: one beat per cycle while out_ready stays high.
//   Stall: when out_ready drops the result register holds; an empty input
//   register still takes one more beat, a full one drops in_ready at once.
//   Reset: the guard comes up disabled with all counters cleared and the
//   registers at 200, 20, 10, 1000, 5000 and 3.
module motion_presence_guard_fsm import mpg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [31:0] now_time,
	input  logic [31:0] score_in,
	input  logic        frame_good,
	input  logic        score_good,
	input  logic [1:0]  fault_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] epoch_out,
	output logic [31:0] sequence_out,
	output logic [2:0]  state_out,
	output logic [1:0]  fault_out,
	output logic [31:0] score_out,
	output logic [31:0] time_out,
	output logic [31:0] last_motion_time,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	cfg_t        cfg_q;
	ctx_t        ctx_q;
	ctx_t        ctx_nxt;
	item_t       item_s1;
	logic        valid_s1;
	logic        out_valid_q;
	logic [31:0] score_echo;
	logic        adv_s1;
	logic        adv_s2;

	// Result register may load when empty or being drained
	assign adv_s2   = !out_valid_q || out_ready;
	assign adv_s1   = valid_s1 && adv_s2;
	assign in_ready = !valid_s1 || adv_s2;
	assign cfg_ready = 1'b1;

	// Configuration registers; writes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_period <= 32'd200;
			cfg_q.on_level      <= 32'd20;
			cfg_q.off_level     <= 32'd10;
			cfg_q.debounce_time <= 32'd1000;
			cfg_q.absence_time  <= 32'd5000;
			cfg_q.failure_limit <= 8'd3;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SAMPLE_PERIOD: cfg_q.sample_period <= cfg_data;
				REG_ON_LEVEL:      cfg_q.on_level      <= cfg_data;
				REG_OFF_LEVEL:     cfg_q.off_level     <= cfg_data;
				REG_DEBOUNCE:      cfg_q.debounce_time <= cfg_data;
				REG_ABSENCE:       cfg_q.absence_time  <= cfg_data;
				REG_FAIL_LIMIT:    cfg_q.failure_limit <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// Input register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Input register: payload, captured on an accepted beat
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.mode       <= mode_t'(mode);
			item_s1.now_time   <= now_time;
			item_s1.score      <= score_in;
			item_s1.frame_good <= frame_good;
			item_s1.score_good <= score_good;
			item_s1.fault_in   <= fault_in;
		end
	end

	mpg_step u_step (
		.cur        (ctx_q),
		.item       (item_s1),
		.cfg        (cfg_q),
		.nxt        (ctx_nxt),
		.score_echo (score_echo)
	);

	// Guard context advances once per item as it moves to the result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q.state         <= ST_DISABLED;
			ctx_q.fault         <= FAULT_NONE;
			ctx_q.epoch         <= '0;
			ctx_q.sequence_cnt  <= '0;
			ctx_q.bad_run       <= '0;
			ctx_q.pending_start <= '0;
			ctx_q.last_motion   <= '0;
		end else if (adv_s1) begin
			ctx_q <= ctx_nxt;
		end
	end

	// Result register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s2) begin
			out_valid_q <= valid_s1;
		end
	end

	// Result register: payload, held while the receiver stalls
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			epoch_out        <= ctx_nxt.epoch;
			sequence_out     <= ctx_nxt.sequence_cnt;
			state_out        <= state_code(ctx_nxt.state);
			fault_out        <= ctx_nxt.fault;
			score_out        <= score_echo;
			time_out         <= item_s1.now_time;
			last_motion_time <= ctx_nxt.last_motion;
		end
	end

	assign out_valid = out_valid_q;

`ifndef NO_ASSERTIONS
	// Context only moves when an item passes to the result stage
	a_ctx_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> $stable(ctx_q))
		else $error("guard context changed without an item");

	// Transition counter steps by one at most
	a_seq_step: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> (ctx_q.sequence_cnt == $past(ctx_q.sequence_cnt)) ||
		           (ctx_q.sequence_cnt == $past(ctx_q.sequence_cnt) + 32'd1))
		else $error("sequence counter jumped");

	// A fault code is only held in the fault state
	a_fault_code: assert property (@(posedge clk) disable iff (!arst_n)
		(ctx_q.state != ST_FAULT) |-> (ctx_q.fault == FAULT_NONE))
		else $error("fault code outside fault state");

	// Disabled guard carries no run, pending or motion history
	a_disabled_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(ctx_q.state == ST_DISABLED) |->
		(ctx_q.bad_run == 8'd0 && ctx_q.last_motion == 32'd0 &&
		 ctx_q.pending_start == 32'd0))
		else $error("disabled guard holds stale history");

	// An item moving forward always produces a result beat
	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> out_valid_q)
		else $error("item lost between stages");
`endif

endmodule
